>>> design/wme_pkg.sv
package wme_pkg;

    // Sizes fixed by the item fields.
    localparam int ADDR_W     = 12;
    localparam int CHAR_W     = 8;
    localparam int OFFSET_W   = 14;
    localparam int LEN_W      = 13;
    localparam int ANTI_W     = 14;
    localparam int MAX_ANTI   = 16383;

    // Default store depth in characters.
    localparam int MAX_SEQ_LEN_DEFAULT = 4096;

    // Characters compared in one step. The stores are interleaved over this many
    // banks, so it must be a power of two of at least two.
    localparam int CHARS_PER_COMPARE = 8;
    localparam int CPC_LOG2          = $clog2(CHARS_PER_COMPARE);
    localparam int LANE_CNT_W        = CPC_LOG2 + 1;

    // Signed width for sequence positions, lengths and antidiagonals.
    localparam int POS_W = 18;

    // Entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        FUNC_WRITE_PATTERN = 2'd0,
        FUNC_WRITE_TEXT    = 2'd1,
        FUNC_EXTEND        = 2'd2
    } func_t;

    typedef enum logic {
        CFG_PATTERN_LENGTH = 1'b0,
        CFG_TEXT_LENGTH    = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_WRITE_PATTERN,
        OP_WRITE_TEXT,
        OP_EXTEND
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FINISH
    } back_state_t;

    // One classified item as it travels from front to back.
    typedef struct packed {
        op_t                        op;
        logic [ADDR_W-1:0]          addr;
        logic [CHAR_W-1:0]          value;
        logic signed [OFFSET_W-1:0] diagonal;
        logic signed [POS_W-1:0]    text_pos;
        logic signed [POS_W-1:0]    pat_pos;
        logic                       first;
        logic                       last;
        logic                       null_diag;
    } item_t;

endpackage

>>> design/wme_front.sv
module wme_front
    import wme_pkg::*;
#(
    parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_DEFAULT
) (
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_func,
    input  logic [ADDR_W-1:0]          s_char_addr,
    input  logic [CHAR_W-1:0]          s_char_value,
    input  logic signed [OFFSET_W-1:0] s_diagonal,
    input  logic signed [OFFSET_W-1:0] s_start_offset,
    input  logic                       s_first_diag,
    input  logic                       s_last_diag,
    output logic                       push_valid,
    output item_t                      push_item,
    input  logic                       push_ready
);

    logic keep;
    logic addr_in_range;

    // A load address past the store depth is dropped here.
    assign addr_in_range = (POS_W'(s_char_addr) < POS_W'(MAX_SEQ_LEN));

    // Decode the function code and fill in the start positions of a diagonal.
    always_comb begin
        push_item.addr      = s_char_addr;
        push_item.value     = s_char_value;
        push_item.diagonal  = s_diagonal;
        push_item.text_pos  = POS_W'(s_start_offset);
        push_item.pat_pos   = POS_W'(s_start_offset) - POS_W'(s_diagonal);
        push_item.first     = s_first_diag;
        push_item.last      = s_last_diag;
        push_item.null_diag = s_start_offset[OFFSET_W-1];
        push_item.op        = OP_EXTEND;
        keep                = 1'b0;
        case (func_t'(s_func))
            FUNC_WRITE_PATTERN: begin
                push_item.op = OP_WRITE_PATTERN;
                keep         = addr_in_range;
            end
            FUNC_WRITE_TEXT: begin
                push_item.op = OP_WRITE_TEXT;
                keep         = addr_in_range;
            end
            FUNC_EXTEND: begin
                push_item.op = OP_EXTEND;
                keep         = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Dropped items complete their transfer without entering the queue.
    assign s_ready    = push_ready;
    assign push_valid = s_valid && keep;

endmodule

>>> design/wme_queue.sv
module wme_queue
    import wme_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    input  item_t push_item,
    output logic  push_ready,
    output logic  pop_valid,
    output item_t pop_item,
    input  logic  pop_ready
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/wme_back.sv
module wme_back
    import wme_pkg::*;
#(
    parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [LEN_W-1:0]    cfg_data,
    input  logic                pop_valid,
    input  item_t               pop_item,
    output logic                pop_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [OFFSET_W-1:0] m_new_offset,
    output logic [ANTI_W-1:0]   m_max_antidiagonal,
    output logic                m_wave_done
);

    localparam int ROWS  = (MAX_SEQ_LEN + CHARS_PER_COMPARE - 1) / CHARS_PER_COMPARE;
    localparam int ROW_W = $clog2(ROWS);

    // Banked character stores: bank b holds the positions congruent to b.
    logic [CHAR_W-1:0] pat_mem  [CHARS_PER_COMPARE][ROWS];
    logic [CHAR_W-1:0] text_mem [CHARS_PER_COMPARE][ROWS];
    logic [CHAR_W-1:0] pat_rd_reg  [CHARS_PER_COMPARE];
    logic [CHAR_W-1:0] text_rd_reg [CHARS_PER_COMPARE];
    logic [ROW_W-1:0]  pat_row  [CHARS_PER_COMPARE];
    logic [ROW_W-1:0]  text_row [CHARS_PER_COMPARE];
    logic [CPC_LOG2-1:0] pat_skew  [CHARS_PER_COMPARE];
    logic [CPC_LOG2-1:0] text_skew [CHARS_PER_COMPARE];

    back_state_t               state_reg, state_next;
    logic signed [POS_W-1:0]   pat_pos_reg, pat_pos_next;
    logic signed [POS_W-1:0]   text_pos_reg, text_pos_next;
    logic signed [OFFSET_W-1:0] diag_reg, diag_next;
    logic                      first_reg, first_next;
    logic                      last_reg, last_next;
    logic                      null_reg, null_next;
    logic [LEN_W-1:0]          plen_reg;
    logic [LEN_W-1:0]          tlen_reg;
    logic [ANTI_W-1:0]         running_max_reg, running_max_next;
    logic                      m_valid_reg, m_valid_next;
    logic [OFFSET_W-1:0]       m_new_offset_reg, m_new_offset_next;
    logic [ANTI_W-1:0]         m_max_reg, m_max_next;
    logic                      m_done_reg, m_done_next;

    logic                      pat_we;
    logic                      text_we;
    logic [CPC_LOG2-1:0]       wr_bank;
    logic [ROW_W-1:0]          wr_row;

    logic signed [POS_W-1:0]   plen_c;
    logic signed [POS_W-1:0]   tlen_c;
    logic signed [POS_W-1:0]   rem_pat;
    logic signed [POS_W-1:0]   rem_text;
    logic signed [POS_W-1:0]   rem_min;
    logic [LANE_CNT_W-1:0]     lane_limit;
    logic [CHARS_PER_COMPARE-1:0] lane_eq;
    logic [LANE_CNT_W-1:0]     run_len;
    logic                      run_stop;

    logic signed [POS_W-1:0]   anti;
    logic signed [POS_W-1:0]   anti_sat;
    logic [ANTI_W-1:0]         max_base;
    logic signed [POS_W-1:0]   max_base_ext;
    logic [ANTI_W-1:0]         max_new;
    logic                      out_free;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= '0;
            tlen_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_PATTERN_LENGTH: plen_reg <= cfg_data;
                CFG_TEXT_LENGTH:    tlen_reg <= cfg_data;
                default:            plen_reg <= plen_reg;
            endcase
        end
    end

    // Store writes come straight from the head of the queue.
    assign pat_we  = (state_reg == ST_IDLE) && pop_valid && (pop_item.op == OP_WRITE_PATTERN);
    assign text_we = (state_reg == ST_IDLE) && pop_valid && (pop_item.op == OP_WRITE_TEXT);
    assign wr_bank = pop_item.addr[CPC_LOG2-1:0];
    assign wr_row  = ROW_W'(POS_W'(pop_item.addr) >> CPC_LOG2);

    // Each bank reads the row holding its character of the current window.
    always_comb begin
        for (int b = 0; b < CHARS_PER_COMPARE; b++) begin
            pat_skew[b]  = CPC_LOG2'(CPC_LOG2'(b) - pat_pos_reg[CPC_LOG2-1:0]);
            text_skew[b] = CPC_LOG2'(CPC_LOG2'(b) - text_pos_reg[CPC_LOG2-1:0]);
            pat_row[b]   = ROW_W'((pat_pos_reg + POS_W'(pat_skew[b])) >> CPC_LOG2);
            text_row[b]  = ROW_W'((text_pos_reg + POS_W'(text_skew[b])) >> CPC_LOG2);
        end
    end

    // Pattern store.
    always_ff @(posedge aclk) begin
        for (int b = 0; b < CHARS_PER_COMPARE; b++) begin
            if (pat_we && (wr_bank == CPC_LOG2'(b))) begin
                pat_mem[b][wr_row] <= pop_item.value;
            end
            pat_rd_reg[b] <= pat_mem[b][pat_row[b]];
        end
    end

    // Text store.
    always_ff @(posedge aclk) begin
        for (int b = 0; b < CHARS_PER_COMPARE; b++) begin
            if (text_we && (wr_bank == CPC_LOG2'(b))) begin
                text_mem[b][wr_row] <= pop_item.value;
            end
            text_rd_reg[b] <= text_mem[b][text_row[b]];
        end
    end

    // Characters left before either sequence ends, capped at one window.
    assign plen_c   = (POS_W'(plen_reg) > POS_W'(MAX_SEQ_LEN)) ? POS_W'(MAX_SEQ_LEN)
                                                               : POS_W'(plen_reg);
    assign tlen_c   = (POS_W'(tlen_reg) > POS_W'(MAX_SEQ_LEN)) ? POS_W'(MAX_SEQ_LEN)
                                                               : POS_W'(tlen_reg);
    assign rem_pat  = plen_c - pat_pos_reg;
    assign rem_text = tlen_c - text_pos_reg;
    assign rem_min  = (rem_pat < rem_text) ? rem_pat : rem_text;

    always_comb begin
        if (pat_pos_reg[POS_W-1] || (rem_min <= 0)) begin
            lane_limit = '0;
        end else if (rem_min > POS_W'(CHARS_PER_COMPARE)) begin
            lane_limit = LANE_CNT_W'(CHARS_PER_COMPARE);
        end else begin
            lane_limit = LANE_CNT_W'(rem_min);
        end
    end

    // Rotate the bank outputs into window order and compare lane by lane.
    always_comb begin
        for (int j = 0; j < CHARS_PER_COMPARE; j++) begin
            lane_eq[j] = (LANE_CNT_W'(j) < lane_limit)
                ? (pat_rd_reg[CPC_LOG2'(pat_pos_reg[CPC_LOG2-1:0] + CPC_LOG2'(j))] ==
                   text_rd_reg[CPC_LOG2'(text_pos_reg[CPC_LOG2-1:0] + CPC_LOG2'(j))])
                : 1'b0;
        end
    end

    // Length of the leading run of matching lanes.
    always_comb begin
        run_len  = '0;
        run_stop = 1'b0;
        for (int j = 0; j < CHARS_PER_COMPARE; j++) begin
            if (!run_stop && lane_eq[j]) begin
                run_len = LANE_CNT_W'(run_len + 1'b1);
            end else begin
                run_stop = 1'b1;
            end
        end
    end

    // Antidiagonal of the finished diagonal and the updated running maximum.
    assign anti         = (text_pos_reg <<< 1) - POS_W'(diag_reg);
    assign anti_sat     = (anti > POS_W'(MAX_ANTI)) ? POS_W'(MAX_ANTI) : anti;
    assign max_base     = first_reg ? '0 : running_max_reg;
    assign max_base_ext = POS_W'(max_base);
    assign max_new      = (!null_reg && (anti_sat > max_base_ext)) ? ANTI_W'(anti_sat)
                                                                   : max_base;
    assign out_free     = !m_valid_reg || m_ready;

    // Sequencer: take an item, step the compare window, deliver the result.
    always_comb begin
        state_next        = state_reg;
        pat_pos_next      = pat_pos_reg;
        text_pos_next     = text_pos_reg;
        diag_next         = diag_reg;
        first_next        = first_reg;
        last_next         = last_reg;
        null_next         = null_reg;
        running_max_next  = running_max_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_new_offset_next = m_new_offset_reg;
        m_max_next        = m_max_reg;
        m_done_next       = m_done_reg;
        pop_ready         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid && (pop_item.op == OP_EXTEND)) begin
                    pat_pos_next  = pop_item.pat_pos;
                    text_pos_next = pop_item.text_pos;
                    diag_next     = pop_item.diagonal;
                    first_next    = pop_item.first;
                    last_next     = pop_item.last;
                    null_next     = pop_item.null_diag;
                    state_next    = pop_item.null_diag ? ST_FINISH : ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                pat_pos_next  = pat_pos_reg + POS_W'(run_len);
                text_pos_next = text_pos_reg + POS_W'(run_len);
                if (run_len == LANE_CNT_W'(CHARS_PER_COMPARE)) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    running_max_next  = max_new;
                    m_valid_next      = 1'b1;
                    m_new_offset_next = text_pos_reg[OFFSET_W-1:0];
                    m_max_next        = max_new;
                    m_done_next       = last_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            running_max_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            running_max_reg <= running_max_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Working and result payload.
    always_ff @(posedge aclk) begin
        pat_pos_reg      <= pat_pos_next;
        text_pos_reg     <= text_pos_next;
        diag_reg         <= diag_next;
        first_reg        <= first_next;
        last_reg         <= last_next;
        null_reg         <= null_next;
        m_new_offset_reg <= m_new_offset_next;
        m_max_reg        <= m_max_next;
        m_done_reg       <= m_done_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_new_offset       = m_new_offset_reg;
    assign m_max_antidiagonal = m_max_reg;
    assign m_wave_done        = m_done_reg;

`ifndef ASSERT_OFF
    // A read is always followed by its compare.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> (state_reg == ST_CMP))
        else $error("compare step did not follow a store read");

    // Both indices advance together, so the diagonal is kept while extending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_READ || state_reg == ST_CMP) && !null_reg)
        |-> (text_pos_reg - pat_pos_reg == POS_W'(diag_reg)))
        else $error("text and pattern indices left their diagonal");

    // The run never goes past the end of either sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (run_len <= lane_limit))
        else $error("match run exceeds the characters left in the sequences");

    // A new result is only loaded from the finishing step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared without a finished diagonal");
`endif

endmodule

>>> design/wavefront_match_extend.sv
// Channel   | Handshake         | Payload
// ----------+-------------------+--------------------------------------------------
// config    | cfg_we            | cfg_index, cfg_data
// input     | s_valid / s_ready | s_func, s_char_addr, s_char_value, s_diagonal,
//           |                   | s_start_offset, s_first_diag, s_last_diag
// result    | m_valid / m_ready | m_new_offset, m_max_antidiagonal, m_wave_done
//
// The front takes one transfer per cycle while the two-entry queue has room.
// The back takes a load in its idle step and sends a null diagonal straight to its
// finishing step. For any other diagonal it repeats a store read and a compare over one
// bank-interleaved window until a window does not match in full, and then finishes.
// Reset clears the queue, the sequencer, the lengths and the running maximum; the
// character stores hold whatever was written. A stalled result holds the back in its
// finishing step, and the queue then fills and lowers s_ready.
module wavefront_match_extend
    import wme_pkg::*;
#(
    parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [LEN_W-1:0]           cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_func,
    input  logic [ADDR_W-1:0]          s_char_addr,
    input  logic [CHAR_W-1:0]          s_char_value,
    input  logic signed [OFFSET_W-1:0] s_diagonal,
    input  logic signed [OFFSET_W-1:0] s_start_offset,
    input  logic                       s_first_diag,
    input  logic                       s_last_diag,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [OFFSET_W-1:0] m_new_offset,
    output logic [ANTI_W-1:0]          m_max_antidiagonal,
    output logic                       m_wave_done
);

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    wme_front #(
        .MAX_SEQ_LEN(MAX_SEQ_LEN)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_char_addr    (s_char_addr),
        .s_char_value   (s_char_value),
        .s_diagonal     (s_diagonal),
        .s_start_offset (s_start_offset),
        .s_first_diag   (s_first_diag),
        .s_last_diag    (s_last_diag),
        .push_valid     (push_valid),
        .push_item      (push_item),
        .push_ready     (push_ready)
    );

    wme_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    wme_back #(
        .MAX_SEQ_LEN(MAX_SEQ_LEN)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .pop_valid          (pop_valid),
        .pop_item           (pop_item),
        .pop_ready          (pop_ready),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_new_offset       (m_new_offset),
        .m_max_antidiagonal (m_max_antidiagonal),
        .m_wave_done        (m_wave_done)
    );

endmodule
